FILE: rtl/ifcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ifcp_pkg;

  localparam int NUM_COLORS = 16;

  localparam logic [7:0] CODE_BOLD      = 8'h02;
  localparam logic [7:0] CODE_COLOR     = 8'h03;
  localparam logic [7:0] CODE_RESET     = 8'h0F;
  localparam logic [7:0] CODE_ITALIC    = 8'h1D;
  localparam logic [7:0] CODE_UNDERLINE = 8'h1F;
  localparam logic [7:0] CODE_COMMA     = 8'h2C;
  localparam logic [7:0] CODE_DIGIT_0   = 8'h30;
  localparam logic [7:0] CODE_DIGIT_9   = 8'h39;

  // two decimal digits give at most 99
  localparam int COLOR_NUM_COUNT = 100;

  typedef enum logic [2:0] {
    PH_PLAIN = 3'd0,
    PH_FG1   = 3'd1,
    PH_FG2   = 3'd2,
    PH_COMMA = 3'd3,
    PH_BG1   = 3'd4,
    PH_BG2   = 3'd5
  } ifcp_phase_t;

  typedef struct packed {
    logic        bold;
    logic        italic;
    logic        underline;
    logic        fore_valid;
    logic [3:0]  fore_index;
    logic        back_valid;
    logic [3:0]  back_index;
    ifcp_phase_t phase;
    logic [3:0]  first_digit;
  } ifcp_state_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       bold_on;
    logic       italic_on;
    logic       underline_on;
    logic       fore_valid;
    logic [3:0] fore_index;
    logic       back_valid;
    logic [3:0] back_index;
  } ifcp_result_t;

  localparam ifcp_state_t STATE_RESET = '{
    bold:        1'b0,
    italic:      1'b0,
    underline:   1'b0,
    fore_valid:  1'b0,
    fore_index:  4'd0,
    back_valid:  1'b0,
    back_index:  4'd0,
    phase:       PH_PLAIN,
    first_digit: 4'd0
  };

endpackage

`default_nettype wire

FILE: rtl/ifcp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ifcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last;

  modport source (output valid, output text_byte, output last, input ready);
  modport sink   (input valid, input text_byte, input last, output ready);
endinterface

interface ifcp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       bold_on;
  logic       italic_on;
  logic       underline_on;
  logic       fore_valid;
  logic [3:0] fore_index;
  logic       back_valid;
  logic [3:0] back_index;

  modport source (output valid, output char_out, output bold_on, output italic_on,
                  output underline_on, output fore_valid, output fore_index,
                  output back_valid, output back_index, input ready);
  modport sink   (input valid, input char_out, input bold_on, input italic_on,
                  input underline_on, input fore_valid, input fore_index,
                  input back_valid, input back_index, output ready);
endinterface

`default_nettype wire

FILE: rtl/ifcp_step.sv
`timescale 1ns / 1ps
`default_nettype none

module ifcp_step
  import ifcp_pkg::*;
(
  input  ifcp_state_t  state,
  input  logic [7:0]   text_byte,
  input  logic         last,
  output ifcp_state_t  state_nxt,
  output logic         emit,
  output ifcp_result_t result
);

  logic        is_digit;
  logic        is_comma;
  logic        continues;
  logic [6:0]  two_digit_num;
  logic [3:0]  one_digit_idx;
  logic [3:0]  two_digit_idx;
  logic [3:0]  color_mod_lut [0:COLOR_NUM_COUNT-1];
  ifcp_phase_t phase_nxt;
  ifcp_state_t attr;

  assign is_digit = (text_byte >= CODE_DIGIT_0) && (text_byte <= CODE_DIGIT_9);
  assign is_comma = (text_byte == CODE_COMMA);

  // constant lookup: color number to palette index
  for (genvar n = 0; n < COLOR_NUM_COUNT; n++) begin : g_color_mod
    assign color_mod_lut[n] = 4'(n % NUM_COLORS);
  end

  // first*10 + d as shifts and adds, at most 99
  assign two_digit_num = {state.first_digit, 3'b000} + {2'b00, state.first_digit, 1'b0}
                       + {3'b000, text_byte[3:0]};
  assign one_digit_idx = color_mod_lut[{3'b000, text_byte[3:0]}];
  assign two_digit_idx = color_mod_lut[two_digit_num];

  // does this byte extend the color sequence in progress
  always_comb begin
    case (state.phase)
      PH_FG1:   continues = is_digit;
      PH_FG2:   continues = is_digit || is_comma;
      PH_COMMA: continues = is_comma;
      PH_BG1:   continues = is_digit;
      PH_BG2:   continues = is_digit;
      default:  continues = 1'b0;
    endcase
  end

  // next parse phase
  always_comb begin
    phase_nxt = PH_PLAIN;
    if (continues) begin
      case (state.phase)
        PH_FG1:   phase_nxt = PH_FG2;
        PH_FG2:   phase_nxt = is_digit ? PH_COMMA : PH_BG1;
        PH_COMMA: phase_nxt = PH_BG1;
        PH_BG1:   phase_nxt = PH_BG2;
        default:  phase_nxt = PH_PLAIN;
      endcase
    end else if (text_byte == CODE_COLOR) begin
      phase_nxt = PH_FG1;
    end
  end

  // attributes and result
  always_comb begin
    attr = state;
    emit = 1'b0;
    if (continues) begin
      if (is_digit) begin
        case (state.phase)
          PH_FG1: begin
            attr.first_digit = text_byte[3:0];
            attr.fore_valid  = 1'b1;
            attr.fore_index  = one_digit_idx;
          end
          PH_FG2: begin
            attr.fore_valid = 1'b1;
            attr.fore_index = two_digit_idx;
          end
          PH_BG1: begin
            attr.first_digit = text_byte[3:0];
            attr.back_valid  = 1'b1;
            attr.back_index  = one_digit_idx;
          end
          PH_BG2: begin
            attr.back_valid = 1'b1;
            attr.back_index = two_digit_idx;
          end
          default: begin
            attr = state;
          end
        endcase
      end
    end else begin
      // bare color code clears both colors before the byte is taken as text
      if (state.phase == PH_FG1) begin
        attr.fore_valid = 1'b0;
        attr.fore_index = 4'd0;
        attr.back_valid = 1'b0;
        attr.back_index = 4'd0;
      end
      case (text_byte)
        CODE_BOLD:      attr.bold      = ~attr.bold;
        CODE_ITALIC:    attr.italic    = ~attr.italic;
        CODE_UNDERLINE: attr.underline = ~attr.underline;
        CODE_RESET: begin
          attr.bold       = 1'b0;
          attr.italic     = 1'b0;
          attr.underline  = 1'b0;
          attr.fore_valid = 1'b0;
          attr.fore_index = 4'd0;
          attr.back_valid = 1'b0;
          attr.back_index = 4'd0;
        end
        CODE_COLOR: begin
          emit = 1'b0;
        end
        default: begin
          emit = 1'b1;
        end
      endcase
    end
    attr.phase = phase_nxt;

    result.char_out     = text_byte;
    result.bold_on      = attr.bold;
    result.italic_on    = attr.italic;
    result.underline_on = attr.underline;
    result.fore_valid   = attr.fore_valid;
    result.fore_index   = attr.fore_valid ? attr.fore_index : 4'd0;
    result.back_valid   = attr.back_valid;
    result.back_index   = attr.back_valid ? attr.back_index : 4'd0;

    state_nxt = last ? STATE_RESET : attr;
  end

endmodule

`default_nettype wire

FILE: rtl/irc_format_code_parser_core.sv
// Chat formatting-code parser.
// in_ch carries one message byte per beat (text_byte, last). Format codes
// update bold/italic/underline and the foreground/background colors and are
// dropped; every other byte comes out on out_ch with its current attributes.
// A byte with last set is parsed as usual, then all attributes return to
// their defaults.
// Throughput: one byte per cycle while in_ch.ready is high. The parse is one
// combinational step between the parser state registers and the result register.
// A text byte's result is registered in the output register, or in the skid
// register while a beat waits there untaken; format codes produce no beat.
// The result path has a two-entry buffer (output register plus skid
// register), so in_ch stays ready while one result waits. in_ch.ready drops
// only when both entries are full and rises again once out_ch takes a beat.
// Reset (rst_n low, synchronous) clears all attributes, the parse phase and
// both buffer entries.
`timescale 1ns / 1ps
`default_nettype none

module irc_format_code_parser_core
  import ifcp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  ifcp_in_if.sink    in_ch,
  ifcp_out_if.source out_ch
);

  ifcp_state_t  state_r;
  ifcp_state_t  state_nxt;
  logic         emit;
  ifcp_result_t result;

  ifcp_result_t out_data_r;
  ifcp_result_t skid_data_r;
  logic         out_valid_r;
  logic         skid_valid_r;

  logic in_beat;
  logic out_beat;
  logic push;

  assign in_ch.ready = ~skid_valid_r;
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign out_beat    = out_valid_r && out_ch.ready;
  assign push        = in_beat && emit;

  ifcp_step u_step (
    .state     (state_r),
    .text_byte (in_ch.text_byte),
    .last      (in_ch.last),
    .state_nxt (state_nxt),
    .emit      (emit),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (in_beat) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_beat) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !out_beat) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_beat) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_beat) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (out_valid_r && !out_beat) begin
        skid_data_r <= result;
      end else begin
        out_data_r <= result;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.char_out     = out_data_r.char_out;
  assign out_ch.bold_on      = out_data_r.bold_on;
  assign out_ch.italic_on    = out_data_r.italic_on;
  assign out_ch.underline_on = out_data_r.underline_on;
  assign out_ch.fore_valid   = out_data_r.fore_valid;
  assign out_ch.fore_index   = out_data_r.fore_index;
  assign out_ch.back_valid   = out_data_r.back_valid;
  assign out_ch.back_index   = out_data_r.back_index;

  // skid entry is only ever filled behind a held output entry
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while output register empty");

  // end of message returns the parser to its defaults
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && in_ch.last) |=> (state_r == STATE_RESET))
    else $error("state not cleared after last beat");

  // a result with no foreground color set shows palette index zero
  a_index_masked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.fore_valid) |-> (out_data_r.fore_index == 4'd0))
    else $error("foreground index nonzero while not valid");

  // a full buffer with no drain must keep refusing input
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ch.ready) |=> !in_ch.ready)
    else $error("input taken while result buffer full");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ifcp_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SHOW_MAX     = 100;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ifcp_in_if  in_ch ();
  ifcp_out_if out_ch ();

  irc_format_code_parser_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle odds in percent, per side
  int unsigned in_idle_pct  = 21;
  int unsigned out_idle_pct = 21;

  int unsigned err_count   = 0;
  int unsigned bytes_sent  = 0;
  int unsigned beats_seen  = 0;
  int unsigned msgs_sent   = 0;
  int unsigned cycle_count = 0;

  // shadow of the parser attributes
  logic        attr_bold;
  logic        attr_italic;
  logic        attr_under;
  logic        fore_set;
  logic [3:0]  fore_idx;
  logic        back_set;
  logic [3:0]  back_idx;
  logic [3:0]  pending_digit;
  ifcp_phase_t parse_ph;

  ifcp_result_t styled_char_q[$];
  logic [7:0]   msg_bytes[$];

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.text_byte = 8'h00;
    in_ch.last      = 1'b0;
    out_ch.ready    = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = ($urandom_range(99) >= out_idle_pct);
    end
  end

  function automatic logic [3:0] palette_of(input int unsigned num);
    return 4'(num % NUM_COLORS);
  endfunction

  task automatic clear_attrs();
    attr_bold     = 1'b0;
    attr_italic   = 1'b0;
    attr_under    = 1'b0;
    fore_set      = 1'b0;
    fore_idx      = 4'd0;
    back_set      = 1'b0;
    back_idx      = 4'd0;
    pending_digit = 4'd0;
    parse_ph      = PH_PLAIN;
  endtask

  // byte outside a color sequence: format code or styled character
  task automatic apply_text_byte(input logic [7:0] b);
    ifcp_result_t r;
    parse_ph = PH_PLAIN;
    case (b)
      CODE_BOLD:      attr_bold   = ~attr_bold;
      CODE_ITALIC:    attr_italic = ~attr_italic;
      CODE_UNDERLINE: attr_under  = ~attr_under;
      CODE_RESET: begin
        attr_bold   = 1'b0;
        attr_italic = 1'b0;
        attr_under  = 1'b0;
        fore_set    = 1'b0;
        fore_idx    = 4'd0;
        back_set    = 1'b0;
        back_idx    = 4'd0;
      end
      CODE_COLOR:     parse_ph = PH_FG1;
      default: begin
        r.char_out     = b;
        r.bold_on      = attr_bold;
        r.italic_on    = attr_italic;
        r.underline_on = attr_under;
        r.fore_valid   = fore_set;
        r.fore_index   = fore_set ? fore_idx : 4'd0;
        r.back_valid   = back_set;
        r.back_index   = back_set ? back_idx : 4'd0;
        styled_char_q.push_back(r);
      end
    endcase
  endtask

  task automatic parse_beat(input logic [7:0] b, input logic fin);
    logic       is_dig;
    logic [3:0] dval;
    is_dig = (b >= CODE_DIGIT_0) && (b <= CODE_DIGIT_9);
    dval   = 4'(b - CODE_DIGIT_0);
    case (parse_ph)
      PH_FG1: begin
        if (is_dig) begin
          pending_digit = dval;
          fore_set      = 1'b1;
          fore_idx      = palette_of(dval);
          parse_ph      = PH_FG2;
        end else begin
          // bare color code clears both colors
          fore_set = 1'b0;
          fore_idx = 4'd0;
          back_set = 1'b0;
          back_idx = 4'd0;
          apply_text_byte(b);
        end
      end
      PH_FG2: begin
        if (is_dig) begin
          fore_idx = palette_of(pending_digit * 10 + dval);
          parse_ph = PH_COMMA;
        end else if (b == CODE_COMMA) begin
          parse_ph = PH_BG1;
        end else begin
          apply_text_byte(b);
        end
      end
      PH_COMMA: begin
        if (b == CODE_COMMA) begin
          parse_ph = PH_BG1;
        end else begin
          apply_text_byte(b);
        end
      end
      PH_BG1: begin
        if (is_dig) begin
          pending_digit = dval;
          back_set      = 1'b1;
          back_idx      = palette_of(dval);
          parse_ph      = PH_BG2;
        end else begin
          apply_text_byte(b);
        end
      end
      PH_BG2: begin
        if (is_dig) begin
          back_idx = palette_of(pending_digit * 10 + dval);
          parse_ph = PH_PLAIN;
        end else begin
          apply_text_byte(b);
        end
      end
      default: apply_text_byte(b);
    endcase
    if (fin) begin
      clear_attrs();
    end
  endtask

  task automatic report_mismatch(input string what);
    if (err_count < SHOW_MAX) begin
      $display("ERROR @%0t: %s", $time, what);
    end
    err_count++;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic fin);
    // idle cycle by cycle so the idle share stays near the given odds
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.text_byte = b;
    in_ch.last      = fin;
    do @(posedge clk); while (!in_ch.ready);
    parse_beat(b, fin);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_msg_bytes(input logic last_at_end);
    for (int i = 0; i < msg_bytes.size(); i++) begin
      send_byte(msg_bytes[i], last_at_end && (i == msg_bytes.size() - 1));
    end
    if (last_at_end) begin
      msgs_sent++;
    end
  endtask

  task automatic wait_results_drained();
    in_ch.valid = 1'b0;
    while (styled_char_q.size() != 0) @(negedge clk);
  endtask

  task automatic push_digits(input int unsigned cnt);
    for (int i = 0; i < cnt; i++) begin
      msg_bytes.push_back(8'(CODE_DIGIT_0 + $urandom_range(9)));
    end
  endtask

  task automatic build_random_message();
    int unsigned n_tok;
    int unsigned pick;
    msg_bytes.delete();
    n_tok = $urandom_range(1, 12);
    for (int t = 0; t < n_tok; t++) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        msg_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else if (pick < 50) begin
        case ($urandom_range(3))
          0:       msg_bytes.push_back(CODE_BOLD);
          1:       msg_bytes.push_back(CODE_ITALIC);
          2:       msg_bytes.push_back(CODE_UNDERLINE);
          default: msg_bytes.push_back(CODE_RESET);
        endcase
      end else if (pick < 80) begin
        // color sequence with random digit counts and optional background
        msg_bytes.push_back(CODE_COLOR);
        push_digits($urandom_range(0, 2));
        if ($urandom_range(1)) begin
          msg_bytes.push_back(CODE_COMMA);
          push_digits($urandom_range(0, 2));
        end
      end else if (pick < 90) begin
        if ($urandom_range(1)) begin
          msg_bytes.push_back(CODE_COMMA);
        end else begin
          push_digits(1);
        end
      end else begin
        msg_bytes.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic run_random_messages(input int unsigned n_bytes, input int unsigned drain_every);
    int unsigned goal;
    goal = bytes_sent + n_bytes;
    while (bytes_sent < goal) begin
      build_random_message();
      send_msg_bytes(1'b1);
      if (drain_every != 0 && (msgs_sent % drain_every) == 0) begin
        wait_results_drained();
      end
    end
  endtask

  task automatic test_plain_extremes();
    msg_bytes = '{8'h00, 8'hFF, 8'h80, 8'h16};
    send_msg_bytes(1'b1);
  endtask

  task automatic test_format_toggles();
    msg_bytes = '{CODE_BOLD, CODE_ITALIC, CODE_UNDERLINE, "a", CODE_RESET, "b"};
    send_msg_bytes(1'b0);
  endtask

  task automatic test_color_sequences();
    // two-digit fore and back, then bare color clears, comma emitted as text
    msg_bytes = '{CODE_COLOR, "1", "2", CODE_COMMA, "3", "4", "x", CODE_COLOR, CODE_COMMA};
    send_msg_bytes(1'b0);
    // comma without digit is swallowed; third digit is text
    msg_bytes = '{CODE_COLOR, "5", CODE_COMMA, "y", CODE_COLOR, "9", "9", "7"};
    send_msg_bytes(1'b0);
    msg_bytes = '{CODE_COLOR, "z", CODE_COLOR, "1"};
    send_msg_bytes(1'b1);
    // message ended inside a sequence, attributes back to defaults
    msg_bytes = '{"q"};
    send_msg_bytes(1'b1);
  endtask

  task automatic test_random_with_idle();
    in_idle_pct  = 21;
    out_idle_pct = 21;
    run_random_messages(800, 0);
  endtask

  task automatic test_random_no_idle();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_random_messages(400, 0);
  endtask

  task automatic test_random_with_drain();
    in_idle_pct  = 21;
    out_idle_pct = 21;
    run_random_messages(700, 7);
  endtask

  always @(posedge clk) begin
    ifcp_result_t got;
    ifcp_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.char_out     = out_ch.char_out;
      got.bold_on      = out_ch.bold_on;
      got.italic_on    = out_ch.italic_on;
      got.underline_on = out_ch.underline_on;
      got.fore_valid   = out_ch.fore_valid;
      got.fore_index   = out_ch.fore_index;
      got.back_valid   = out_ch.back_valid;
      got.back_index   = out_ch.back_index;
      beats_seen++;
      if (styled_char_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat char=%02h", got.char_out));
      end else begin
        want = styled_char_q.pop_front();
        if (got.char_out !== want.char_out)
          report_mismatch($sformatf("char_out %02h exp %02h", got.char_out, want.char_out));
        if (got.bold_on !== want.bold_on)
          report_mismatch($sformatf("bold_on %b exp %b", got.bold_on, want.bold_on));
        if (got.italic_on !== want.italic_on)
          report_mismatch($sformatf("italic_on %b exp %b", got.italic_on, want.italic_on));
        if (got.underline_on !== want.underline_on)
          report_mismatch($sformatf("underline_on %b exp %b",
                                    got.underline_on, want.underline_on));
        if (got.fore_valid !== want.fore_valid)
          report_mismatch($sformatf("fore_valid %b exp %b", got.fore_valid, want.fore_valid));
        if (got.fore_index !== want.fore_index)
          report_mismatch($sformatf("fore_index %0d exp %0d", got.fore_index, want.fore_index));
        if (got.back_valid !== want.back_valid)
          report_mismatch($sformatf("back_valid %b exp %b", got.back_valid, want.back_valid));
        if (got.back_index !== want.back_index)
          report_mismatch($sformatf("back_index %0d exp %0d", got.back_index, want.back_index));
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("simulation failed");
    $finish;
  end

  initial begin
    clear_attrs();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_plain_extremes();
    test_format_toggles();
    test_color_sequences();
    test_random_with_idle();
    test_random_no_idle();
    test_random_with_drain();

    in_ch.valid = 1'b0;
    while (styled_char_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (styled_char_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected beats never arrived", styled_char_q.size()));
    end

    $display("sent %0d bytes in %0d messages, checked %0d styled characters",
             bytes_sent, msgs_sent, beats_seen);
    $display("covered toggles, reset code, fore/back colors, stalls and drained pauses");
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
